@@ sv/swbp_pkg.sv @@
// ----------------------------------------------------------------------------
// swbp_pkg - shared types for the sample word to byte packer
// Holds the command that passes from the front end to the byte emitter.
// ----------------------------------------------------------------------------
package swbp_pkg;

  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;

  // One converted word: one or two bytes for the output stream
  typedef struct packed {
    logic [ByteWidth-1:0] byte0;
    logic [ByteWidth-1:0] byte1;
    logic                 two;
  } swbp_cmd_t;

endpackage

@@ sv/swbp_front.sv @@
// ----------------------------------------------------------------------------
// swbp_front - word classifier and bit packer
// Accepts converter words, keeps the group phase and leftover bits, and
// turns each word into a byte command for the queue.
// ----------------------------------------------------------------------------
module swbp_front
  import swbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_data,
  input  logic                 word_valid,
  input  logic [WordWidth-1:0] word,
  input  logic                 queue_full,
  output logic                 word_ready,
  output logic                 push,
  output swbp_cmd_t            push_cmd
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FOURTH
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       packed_mode;
  logic [5:0] leftover;
  logic [5:0] leftover_next;
  logic [9:0] v;

  assign v          = word[9:0];
  assign word_ready = !queue_full;
  assign push       = word_valid && word_ready;

  // Build the byte command and the state left for the next word
  always_comb begin
    push_cmd      = '0;
    phase_next    = phase;
    leftover_next = leftover;
    if (!packed_mode) begin
      // (v - 512) * 64, low byte first
      push_cmd.byte0 = {v[1:0], 6'b0};
      push_cmd.byte1 = {~v[9], v[8:2]};
      push_cmd.two   = 1'b1;
    end else begin
      case (phase)
        PH_FIRST: begin
          push_cmd.byte0 = v[9:2];
          leftover_next  = {4'b0, v[1:0]};
          phase_next     = PH_SECOND;
        end
        PH_SECOND: begin
          push_cmd.byte0 = {leftover[1:0], v[9:4]};
          leftover_next  = {2'b0, v[3:0]};
          phase_next     = PH_THIRD;
        end
        PH_THIRD: begin
          push_cmd.byte0 = {leftover[3:0], v[9:6]};
          leftover_next  = v[5:0];
          phase_next     = PH_FOURTH;
        end
        PH_FOURTH: begin
          push_cmd.byte0 = {leftover[5:0], v[9:8]};
          push_cmd.byte1 = v[7:0];
          push_cmd.two   = 1'b1;
          leftover_next  = '0;
          phase_next     = PH_FIRST;
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase
    end
  end

  // Hold mode and packing state; a register write starts a new group
  always_ff @(posedge clk) begin
    if (rst) begin
      packed_mode <= 1'b0;
      phase       <= PH_FIRST;
      leftover    <= '0;
    end else if (cfg_valid) begin
      packed_mode <= cfg_data;
      phase       <= PH_FIRST;
      leftover    <= '0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

@@ sv/swbp_fifo.sv @@
// ----------------------------------------------------------------------------
// swbp_fifo - short command queue
// Decouples the packer front end from the byte emitter.
// ----------------------------------------------------------------------------
module swbp_fifo
  import swbp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  swbp_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output swbp_cmd_t pop_cmd
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  swbp_cmd_t           slots [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  assign full    = (count == CntWidth'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Store an item at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/swbp_back.sv @@
// ----------------------------------------------------------------------------
// swbp_back - byte emitter
// Takes commands from the queue and sends their bytes one per cycle,
// marking the final byte of each word with tlast.
// ----------------------------------------------------------------------------
module swbp_back
  import swbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  swbp_cmd_t            queue_cmd,
  output logic                 pop,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [ByteWidth-1:0] out_byte,
  output logic                 out_last
);

  swbp_cmd_t cur;
  logic      busy;
  logic      second;
  logic      done;

  assign out_valid = busy;
  assign out_byte  = second ? cur.byte1 : cur.byte0;
  assign out_last  = second || !cur.two;
  assign done      = busy && out_ready && out_last;
  assign pop       = !queue_empty && (!busy || done);

  // Load the next command when the emitter is idle or the current one is finished
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= queue_cmd;
    end
  end

  // Step through the bytes of the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (pop) begin
      busy   <= 1'b1;
      second <= 1'b0;
    end else if (done) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (busy && out_ready) begin
      second <= 1'b1;
    end
  end

endmodule

@@ sv/sample_word_to_byte_packer.sv @@
// ----------------------------------------------------------------------------
// sample_word_to_byte_packer - converter word to byte stream packer
// Packs 10-bit converter samples into bytes or emits them as signed 16-bit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 16-bit converter word per item; only bits 9..0 count.
//   m_axis carries one byte per item; tlast marks the final byte that a word
//   gives. cfg_valid/cfg_data set packed mode (1) or signed mode (0); write
//   it only while the block is idle. Every write restarts the group of four.
//   Packed mode: words in a group give 1, 1, 1 and 2 bytes, MSB first.
//   Signed mode: each word gives two bytes of (v - 512) * 64, low byte first.
// Path: an accepted word is written into the queue, then loaded into the emitter's
//   command register, from which its first byte is offered.
// Throughput: the emitter sends one byte per cycle while m_axis_tready is high
//   and the queue holds a command. Words are taken while the queue of
//   FIFO_DEPTH commands has room.
// Reset: clears the mode to signed, the group phase, leftover bits and the
//   queue. When the receiver stalls, the current byte holds and the queue
//   fills, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module sample_word_to_byte_packer
  import swbp_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,       // packed_mode
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WordWidth-1:0] s_axis_tdata,   // [15:0] sample_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ByteWidth-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic                 m_axis_tlast    // last_of_run
);

  swbp_cmd_t push_cmd;
  swbp_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  assign cfg_ready = 1'b1;

  swbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .word_valid (s_axis_tvalid),
    .word       (s_axis_tdata),
    .queue_full (full),
    .word_ready (s_axis_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  swbp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .pop_cmd  (pop_cmd)
  );

  swbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .queue_cmd   (pop_cmd),
    .pop         (pop),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_byte    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

@@ tb/sample_word_to_byte_packer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_word_to_byte_packer_tb - self-checking bench for the word packer
// Streams converter words through the packer in both output modes, predicts
// every byte and its last flag, and checks the byte stream in order while
// both sides idle at random, the receiver holds off and the mode changes.
// ----------------------------------------------------------------------------
module sample_word_to_byte_packer_tb
  import swbp_pkg::*;
();

  typedef enum bit {MODE_SIGNED = 1'b0, MODE_PACKED = 1'b1} pack_mode_t;

  typedef struct {
    bit [WordWidth-1:0] word;
    bit                 drain_first;
  } word_item_t;

  typedef struct {
    bit [ByteWidth-1:0] data;
    bit                 last;
  } byte_item_t;

  localparam int StuckLimit   = 1000;
  localparam int RxHoldCycles = 60;

  // Directed words
  bit [WordWidth-1:0] dir_signed[8] = '{
    16'h0000, 16'h03FF, 16'h0200, 16'h01FF, 16'hFFFF, 16'hFC00, 16'h8000, 16'h5555
  };
  bit [WordWidth-1:0] dir_packed_a[10] = '{
    16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
    16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF,
    16'h0123, 16'hFD55
  };
  bit [WordWidth-1:0] dir_packed_b[4] = '{16'h0001, 16'hAE00, 16'h0155, 16'h02AA};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [WordWidth-1:0] s_axis_tdata = '0;   // [15:0] sample_word
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ByteWidth-1:0] m_axis_tdata;        // [7:0] out_byte
  logic                 m_axis_tlast;        // last_of_run

  // Predictor state
  pack_mode_t mode_now   = MODE_SIGNED;
  bit [1:0]   grp_phase  = '0;
  bit [5:0]   carry_bits = '0;

  word_item_t word_queue[$];
  byte_item_t byte_queue[$];

  // Handshake flags, set at the rising edge and consumed at the falling edge
  bit word_taken = 1'b0;
  bit byte_taken = 1'b0;
  bit cfg_taken  = 1'b0;

  int tx_idle_max    = 0;
  int rx_idle_max    = 0;
  int tx_gap         = 0;
  int rx_gap         = 0;
  int rx_hold_cycles = 0;

  int words_planned = 0;
  int words_in      = 0;
  int bytes_out     = 0;
  int cfg_writes    = 0;
  int err_count     = 0;
  int stuck_cycles  = 0;

  sample_word_to_byte_packer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Count a mismatch and print one line for it
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic void push_byte(input bit [ByteWidth-1:0] d, input bit l);
    byte_item_t e;
    e.data = d;
    e.last = l;
    byte_queue.push_back(e);
  endfunction

  // Work out the bytes that one accepted word gives and advance the group
  function automatic void predict_bytes(input bit [WordWidth-1:0] word);
    bit [9:0]  v;
    bit [15:0] scaled;
    v = word[9:0];
    if (mode_now == MODE_SIGNED) begin
      // (v - 512) * 64: flip the top bit of the offset value, shift up by six
      scaled = {~v[9], v[8:0], 6'b0};
      push_byte(scaled[7:0], 1'b0);
      push_byte(scaled[15:8], 1'b1);
    end else begin
      case (grp_phase)
        2'd0: begin
          push_byte(v[9:2], 1'b1);
          carry_bits = {4'b0, v[1:0]};
        end
        2'd1: begin
          push_byte({carry_bits[1:0], v[9:4]}, 1'b1);
          carry_bits = {2'b0, v[3:0]};
        end
        2'd2: begin
          push_byte({carry_bits[3:0], v[9:6]}, 1'b1);
          carry_bits = v[5:0];
        end
        default: begin
          push_byte({carry_bits, v[9:8]}, 1'b0);
          push_byte(v[7:0], 1'b1);
          carry_bits = '0;
        end
      endcase
      grp_phase = grp_phase + 2'd1;
    end
  endfunction

  // Compare one accepted byte with the oldest expectation
  task automatic check_byte();
    byte_item_t e;
    bytes_out++;
    if (byte_queue.size() == 0) begin
      report_mismatch($sformatf("byte %02h with nothing expected", m_axis_tdata));
    end else begin
      e = byte_queue.pop_front();
      if (m_axis_tdata !== e.data)
        report_mismatch($sformatf("byte %0d data %02h, expected %02h",
                                  bytes_out, m_axis_tdata, e.data));
      if (m_axis_tlast !== e.last)
        report_mismatch($sformatf("byte %0d tlast %b, expected %b",
                                  bytes_out, m_axis_tlast, e.last));
    end
  endtask

  // Track every handshake at the rising edge; run the watchdog
  always @(posedge clk) begin : track_handshakes
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        mode_now   = pack_mode_t'(cfg_data);
        grp_phase  = '0;
        carry_bits = '0;
        cfg_taken  = 1'b1;
        moved      = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_bytes(s_axis_tdata);
        words_in++;
        word_taken = 1'b1;
        moved      = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_byte();
        byte_taken = 1'b1;
        moved      = 1'b1;
      end
    end
    if (moved || rst) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("Watchdog: no handshake for %0d cycles", StuckLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer words from the queue, idling a drawn number of cycles between them
  always @(negedge clk) begin : drive_words
    bit         next_valid;
    word_item_t it;
    next_valid = s_axis_tvalid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (word_taken) begin
        word_taken = 1'b0;
        next_valid = 1'b0;
        tx_gap     = $urandom_range(0, tx_idle_max);
      end
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (word_queue.size() > 0 &&
                     !(word_queue[0].drain_first && byte_queue.size() != 0)) begin
          it = word_queue.pop_front();
          s_axis_tdata <= it.word;
          next_valid = 1'b1;
        end
      end
    end
    s_axis_tvalid <= next_valid;
  end

  // Receiver: idle between bytes, or hold off for a long stretch on request
  always @(negedge clk) begin : drive_ready
    bit next_ready;
    if (byte_taken) begin
      byte_taken = 1'b0;
      rx_gap     = $urandom_range(0, rx_idle_max);
    end
    if (rx_hold_cycles > 0) begin
      next_ready = 1'b0;
      rx_hold_cycles--;
    end else if (rx_gap > 0) begin
      next_ready = 1'b0;
      rx_gap--;
    end else begin
      next_ready = 1'b1;
    end
    m_axis_tready <= next_ready;
  end

  task automatic queue_word(input bit [WordWidth-1:0] w, input bit drain);
    word_item_t it;
    it.word        = w;
    it.drain_first = drain;
    word_queue.push_back(it);
    words_planned++;
  endtask

  // Wait until every queued word is taken and every byte has come out
  task automatic wait_drained();
    do @(negedge clk); while (words_in != words_planned || byte_queue.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input pack_mode_t m);
    @(negedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Random word, leaning on the extremes of the sample bits
  function automatic bit [WordWidth-1:0] rand_word();
    bit [5:0] upper;
    upper = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0:       return {upper, 10'h3FF};
      1:       return {upper, 10'h000};
      2:       return {upper, 10'h200};
      3:       return {upper, 10'h1FF};
      default: return WordWidth'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int n;
    int pause_at;
    pack_mode_t m;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Signed mode straight from reset: sample extremes and ignored upper bits
    foreach (dir_signed[i]) queue_word(dir_signed[i], 1'b0);
    wait_drained();

    // Packed mode: full groups, upper bits set, a partial group cut by a write
    write_mode(MODE_PACKED);
    foreach (dir_packed_a[i]) queue_word(dir_packed_a[i], 1'b0);
    wait_drained();
    write_mode(MODE_PACKED);
    foreach (dir_packed_b[i]) queue_word(dir_packed_b[i], 1'b0);
    wait_drained();

    // Random phases across both modes and the idling profiles
    for (int p = 0; p < 12; p++) begin
      m = (p % 2) ? MODE_PACKED : MODE_SIGNED;
      write_mode(m);
      case ((p / 2) % 4)
        0: begin tx_idle_max = 0; rx_idle_max = 0; end
        1: begin tx_idle_max = 5; rx_idle_max = 0; end
        2: begin tx_idle_max = 0; rx_idle_max = 5; end
        default: begin tx_idle_max = 5; rx_idle_max = 5; end
      endcase
      n        = $urandom_range(90, 130);
      pause_at = $urandom_range(20, n - 20);
      @(posedge clk);
      for (int k = 0; k < n; k++) queue_word(rand_word(), k == pause_at);
      if (p % 3 == 1) begin
        @(posedge clk);
        rx_hold_cycles = RxHoldCycles;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d words and %0d bytes over %0d mode writes,", words_in,
             bytes_out, cfg_writes);
    $display("both output modes, partial groups, idling on both sides and back-pressure.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/swbp_pkg.sv
sv/swbp_front.sv
sv/swbp_fifo.sv
sv/swbp_back.sv
sv/sample_word_to_byte_packer.sv
tb/sample_word_to_byte_packer_tb.sv
